[rtl/core/ugr_pkg.sv]
// Package for the uniform grid linear resampler.
// Shared item type and fixed-point constants; no dependencies.
`default_nettype none
package ugr_pkg;
    localparam int unsigned NUM_CH          = 7;
    localparam int unsigned CH_W            = 32;
    localparam int unsigned STEP_W          = 31;
    localparam int unsigned WEIGHT_BITS     = 30;
    localparam int unsigned RECIP_W         = 63;
    localparam int unsigned DEF_MAX_POINTS  = 64;
    localparam int unsigned DEF_FRAC_BITS   = 16;
    localparam logic signed [31:0] KEY_MAX  = 32'sh7FFF_FFFF;

    // One queued sample: channel 0 is the key, then the six value channels.
    typedef struct packed {
        logic                                pass;
        logic [NUM_CH-1:0][CH_W-1:0]         ch;
    } item_t;
endpackage
`default_nettype wire

[rtl/core/ugr_div.sv]
// Restoring divider, one quotient bit per cycle.
// Standalone; uses no package items.
`default_nettype none
module ugr_div #(
    parameter int unsigned NW = 63,
    parameter int unsigned DW = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start_i,
    input  wire logic [NW-1:0] num_i,
    input  wire logic [DW-1:0] den_i,
    output logic               done_o,
    output logic [NW-1:0]      quo_o,
    output logic [DW-1:0]      rem_o
);
    localparam int unsigned CNTW = $clog2(NW + 1);

    logic [NW-1:0]   quo_reg;
    logic [DW-1:0]   rem_reg, den_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg, done_reg;
    logic [DW:0]     trial;
    logic            ge;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start_i) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNTW'(NW);
            quo_reg  <= num_i;
            den_reg  <= den_i;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done_o = done_reg;
    assign quo_o  = quo_reg;
    assign rem_o  = rem_reg;
endmodule
`default_nettype wire

[rtl/core/ugr_front.sv]
// Front end: accepts samples, marks path starts and queues them for the back end.
// Depends on ugr_pkg.
`default_nettype none
module ugr_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [223:0]   s_tdata,
    input  wire logic           s_tuser,
    output logic                q_valid_o,
    output ugr_pkg::item_t      q_item_o,
    input  wire logic           q_pop_i
);
    ugr_pkg::item_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       started_reg;
    logic       push;
    ugr_pkg::item_t new_item;

    assign s_tready  = count_reg != 2'd2;
    assign push      = s_tvalid && s_tready;
    assign q_valid_o = count_reg != 2'd0;
    assign q_item_o  = mem[rd_ptr_reg];

    always_comb begin
        new_item.ch   = s_tdata;
        // The first sample after reset opens a path as well.
        new_item.pass = s_tuser || !started_reg;
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= new_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            count_reg   <= 2'd0;
            started_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg  <= !wr_ptr_reg;
                started_reg <= 1'b1;
            end
            if (q_pop_i) rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop_i};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) q_pop_i |-> count_reg != 2'd0)
        else $error("queue popped while empty");
endmodule
`default_nettype wire

[rtl/core/ugr_back.sv]
// Back end: divisions per segment, weight and channel interpolation, result register.
// Depends on ugr_pkg and ugr_div.
`default_nettype none
module ugr_back #(
    parameter int unsigned MAX_POINTS_PER_SEGMENT = ugr_pkg::DEF_MAX_POINTS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [ugr_pkg::STEP_W-1:0]   step_i,
    input  wire logic                         q_valid_i,
    input  wire ugr_pkg::item_t               q_item_i,
    output logic                              q_pop_o,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [223:0]                      m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);
    localparam int unsigned CW = $clog2(MAX_POINTS_PER_SEGMENT + 1);
    localparam int unsigned NV = ugr_pkg::NUM_CH - 1;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_WGT, S_SUM, S_CHAN, S_EMIT} state_t;

    state_t                 state_reg;
    logic [6:0][31:0]       cur_reg, prev_reg;
    logic signed [31:0]     ngk_reg, g_reg, final_reg;
    logic signed [32:0]     diff_reg [NV];
    logic signed [63:0]     prod_reg [NV];
    logic [CW-1:0]          cnt_reg, total_reg;
    logic                   ovf_reg;
    logic [63:0]            pl_reg;
    logic [62:0]            ph_reg;
    logic [30:0]            w_reg;
    logic                   out_valid_reg, out_last_reg, out_ovf_reg;
    logic [223:0]           out_data_reg;

    logic [30:0]            step;
    logic                   out_free, div_start, out_load;
    logic signed [31:0]     head_key, prev_key;
    logic [31:0]            d_val, gap_val, off;
    logic                   r_done, g_done;
    logic [62:0]            recip;
    logic [31:0]            gq, gr_unused;
    logic [30:0]            gr;
    logic [32:0]            n_pts;
    logic signed [33:0]     pass_ngk, fin_sum;

    assign step     = (step_i == '0) ? 31'd1 : step_i;
    assign out_free = !out_valid_reg || m_tready;
    assign head_key = signed'(q_item_i.ch[0]);
    assign prev_key = signed'(prev_reg[0]);
    assign d_val    = 32'(head_key - prev_key);
    assign gap_val  = 32'(head_key - ngk_reg);
    assign off      = 32'(g_reg - prev_key);
    assign pass_ngk = 34'(head_key) + 34'(step);
    assign n_pts    = {1'b0, gq} + {32'd0, gr != '0};
    assign fin_sum  = 34'(signed'(cur_reg[0])) + 34'(step) - 34'(gr);
    assign gr       = gr_unused[30:0];
    // The output register takes a new beat on a pass-through or an emitted point.
    assign out_load = (state_reg == S_IDLE && q_pop_o && q_item_i.pass)
                   || (state_reg == S_EMIT && out_free);

    always_comb begin
        q_pop_o   = 1'b0;
        div_start = 1'b0;
        if (state_reg == S_IDLE && q_valid_i) begin
            if (q_item_i.pass) q_pop_o = out_free;
            else begin
                q_pop_o   = 1'b1;
                div_start = head_key > ngk_reg;
            end
        end
    end

    ugr_div #(.NW(ugr_pkg::RECIP_W), .DW(32)) u_recip (
        .aclk, .aresetn, .start_i(div_start), .num_i(63'd1 << 62), .den_i(d_val),
        .done_o(r_done), .quo_o(recip), .rem_o()
    );

    ugr_div #(.NW(32), .DW(32)) u_gap (
        .aclk, .aresetn, .start_i(div_start), .num_i(gap_val), .den_i({1'b0, step}),
        .done_o(g_done), .quo_o(gq), .rem_o(gr_unused)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            prev_reg      <= '0;
            ngk_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_pop_o) begin
                        cur_reg <= q_item_i.ch;
                        if (q_item_i.pass) begin
                            out_data_reg  <= q_item_i.ch;
                            out_last_reg  <= 1'b1;
                            out_ovf_reg   <= 1'b0;
                            prev_reg      <= q_item_i.ch;
                            ngk_reg       <= (pass_ngk > 34'(ugr_pkg::KEY_MAX))
                                             ? ugr_pkg::KEY_MAX : pass_ngk[31:0];
                        end else if (div_start) begin
                            for (int i = 0; i < NV; i++)
                                diff_reg[i] <= 33'(signed'(q_item_i.ch[i+1]))
                                             - 33'(signed'(prev_reg[i+1]));
                            g_reg     <= ngk_reg;
                            state_reg <= S_DIV;
                        end else begin
                            prev_reg <= q_item_i.ch;
                        end
                    end
                end
                S_DIV: begin
                    if (r_done && g_done) begin
                        ovf_reg   <= n_pts > 33'(MAX_POINTS_PER_SEGMENT);
                        total_reg <= (n_pts > 33'(MAX_POINTS_PER_SEGMENT))
                                     ? CW'(MAX_POINTS_PER_SEGMENT) : n_pts[CW-1:0];
                        // The grid lands on the first point not below the key.
                        if (gr == '0) final_reg <= signed'(cur_reg[0]);
                        else final_reg <= (fin_sum > 34'(ugr_pkg::KEY_MAX))
                                          ? ugr_pkg::KEY_MAX : fin_sum[31:0];
                        cnt_reg   <= '0;
                        state_reg <= S_WGT;
                    end
                end
                S_WGT: begin
                    pl_reg    <= 64'(off) * 64'(recip[31:0]);
                    ph_reg    <= 63'(off) * 63'(recip[62:32]);
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    w_reg     <= 31'(ph_reg + 63'(pl_reg[63:32]));
                    state_reg <= S_CHAN;
                end
                S_CHAN: begin
                    for (int i = 0; i < NV; i++)
                        prod_reg[i] <= 64'(diff_reg[i] * signed'({2'b0, w_reg}));
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        out_data_reg[31:0]    <= g_reg;
                        for (int i = 0; i < NV; i++)
                            out_data_reg[32*(i+1) +: 32] <= prev_reg[i+1]
                                                          + prod_reg[i][61:30];
                        out_last_reg <= cnt_reg == total_reg - 1'b1;
                        out_ovf_reg  <= ovf_reg;
                        cnt_reg      <= cnt_reg + 1'b1;
                        g_reg        <= 32'(g_reg + signed'({1'b0, step}));
                        if (cnt_reg == total_reg - 1'b1) begin
                            ngk_reg   <= final_reg;
                            prev_reg  <= cur_reg;
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= S_WGT;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CHAN |-> w_reg <= 31'(1 << ugr_pkg::WEIGHT_BITS))
        else $error("interpolation weight above one");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> cnt_reg < total_reg)
        else $error("grid point count past segment total");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> g_reg < signed'(cur_reg[0]))
        else $error("emitted grid key not below sample key");
endmodule
`default_nettype wire

[rtl/core/uniform_grid_linear_resampler_core.sv]
// Top level of the uniform grid linear resampler.
// Depends on ugr_pkg, ugr_front, ugr_back (and ugr_div below it).
//
// Usage:
//  s_ channel: one path sample per beat. s_tdata holds key_x, arr_time, y_pos,
//  vel_x, vel_y, quantile_u, normal_z from the lowest bit up; s_tuser is start_of_path.
//  m_ channel: one resampled point per beat, same channel order in m_tdata;
//  m_tlast marks the last point caused by a sample, m_tuser the grid overflow flag.
//  cfg channel: writes grid_step (unsigned Q15.16); change it only while the block is idle.
//  A path start goes from the queue into the output register without a division. A segment
//  with grid points waits on the reciprocal divider, then works through each emitted
//  point in turn (weight products, weight sum, channel products, output register);
//  the next sample is taken once the last point of the segment is in the output register.
//  Samples that yield no point are popped without a division. A two-entry queue lets
//  samples arrive while the back end is busy. When the receiver stalls the output
//  register holds its beat and the back end waits. Reset clears the path state, the
//  queue and the grid; grid_step returns to 1.0.
`default_nettype none
module uniform_grid_linear_resampler_core #(
    parameter int unsigned MAX_POINTS_PER_SEGMENT = ugr_pkg::DEF_MAX_POINTS,
    parameter int unsigned FRACTION_BITS          = ugr_pkg::DEF_FRAC_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [223:0] s_tdata,   // key_x, arr_time, y_pos, vel_x, vel_y, quantile_u, normal_z
    input  wire logic         s_tuser,   // start_of_path
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [223:0]      m_tdata,   // out_key, out_arr_time .. out_normal_z
    output logic              m_tlast,   // last_of_run
    output logic              m_tuser,   // grid_overflow
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [30:0]  cfg_data   // grid_step
);
    logic [ugr_pkg::STEP_W-1:0] step_reg;
    logic           q_valid, q_pop;
    ugr_pkg::item_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) step_reg <= ugr_pkg::STEP_W'(1) << FRACTION_BITS;
        else if (cfg_valid) step_reg <= cfg_data;
    end

    ugr_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
    );

    ugr_back #(.MAX_POINTS_PER_SEGMENT(MAX_POINTS_PER_SEGMENT)) u_back (
        .aclk, .aresetn, .step_i(step_reg),
        .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
        .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
    );
endmodule
`default_nettype wire

[tb/sv/uniform_grid_linear_resampler_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for uniform_grid_linear_resampler_core.
// Depends on ugr_pkg and the core; predicts every resampled point and checks each beat.
module uniform_grid_linear_resampler_core_tb;

    localparam int unsigned GRID_LIMIT = 64;
    localparam int unsigned STALL_LIMIT = 8000;
    localparam int unsigned SETTLE_CYCLES = 300;

    typedef struct packed {
        logic              start;
        logic [6:0][31:0]  ch;
        logic              typed;
    } sample_t;

    typedef struct packed {
        logic [6:0][31:0]  ch;
        logic              last;
        logic              ovf;
    } point_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [223:0]  s_tdata = '0;
    logic          s_tuser = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [223:0]  m_tdata;
    logic          m_tlast;
    logic          m_tuser;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [30:0]   cfg_data = '0;

    // Predictor state.
    logic [30:0]       grid_step_now = 31'd65536;
    logic [6:0][31:0]  last_sample = '0;
    logic [31:0]       next_grid_key = '0;
    bit                path_open = 1'b0;

    point_t   points_due[$];
    sample_t  directed_rows[$];
    int       failures = 0;
    int       quiet_cycles = 0;
    bit       calm = 1'b0;
    longint   walk_key = 0;

    always #5 aclk = ~aclk;

    uniform_grid_linear_resampler_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    function automatic logic [31:0] clamp_key(longint v);
        return (v > 64'sd2147483647) ? 32'h7FFF_FFFF : v[31:0];
    endfunction

    function automatic longint as_long(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic bit roll_idle();
        return !calm && ($urandom_range(99) < 16);
    endfunction

    // Works out the grid points that one accepted sample produces.
    function automatic void resample_sample(sample_t s);
        longint step, key, x0, d, recip, off, w, diff, v, gap, k;
        int first, n;
        bit ovf;
        point_t p;
        step = (grid_step_now == 0) ? 1 : longint'(grid_step_now);
        key = as_long(s.ch[0]);
        first = points_due.size();
        n = 0;
        ovf = 1'b0;
        if (s.start || !path_open) begin
            p.ch = s.ch;
            p.last = 1'b1;
            p.ovf = 1'b0;
            points_due.insert(points_due.size(), p);
            next_grid_key = clamp_key(key + step);
            path_open = 1'b1;
        end else if (key > as_long(next_grid_key)) begin
            x0 = as_long(last_sample[0]);
            d = key - x0;
            recip = (64'sd1 <<< 62) / d;
            while (key > as_long(next_grid_key) && n < GRID_LIMIT) begin
                off = as_long(next_grid_key) - x0;
                w = (off * recip) >>> 32;
                p.ch[0] = next_grid_key;
                for (int i = 1; i < 7; i++) begin
                    diff = as_long(s.ch[i]) - as_long(last_sample[i]);
                    v = as_long(last_sample[i]) + ((diff * w) >>> ugr_pkg::WEIGHT_BITS);
                    p.ch[i] = v[31:0];
                end
                p.last = 1'b0;
                p.ovf = 1'b0;
                points_due.insert(points_due.size(), p);
                n++;
                next_grid_key = clamp_key(as_long(next_grid_key) + step);
            end
            if (key > as_long(next_grid_key)) begin
                gap = key - as_long(next_grid_key);
                k = (gap + step - 1) / step;
                ovf = 1'b1;
                next_grid_key = clamp_key(as_long(next_grid_key) + k * step);
            end
            for (int i = first; i < points_due.size(); i++)
                points_due[i].ovf = ovf;
            if (n > 0)
                points_due[points_due.size() - 1].last = 1'b1;
        end
        last_sample = s.ch;
    endfunction

    task automatic send_sample(sample_t s);
        @(negedge aclk);
        while (roll_idle()) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = s.start;
        s_tdata = s.ch;
        do @(posedge aclk); while (!s_tready);
        resample_sample(s);
        // A pass-through row carries its own expectation: the sample itself.
        if (s.typed)
            points_due[points_due.size() - 1] = '{ch: s.ch, last: 1'b1, ovf: 1'b0};
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (points_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_grid_step(logic [30:0] value);
        wait_drained();
        // A sample that yields no point may still be in the back end.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        grid_step_now = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic add_row(logic start, logic [31:0] key, logic [31:0] a, logic [31:0] b,
                           logic [31:0] c, logic [31:0] dv, logic [31:0] e, logic [31:0] f,
                           logic typed);
        sample_t s;
        s.start = start;
        s.ch = {f, e, dv, c, b, a, key};
        s.typed = typed;
        directed_rows.insert(directed_rows.size(), s);
    endtask

    function automatic sample_t random_sample(logic [30:0] step_raw);
        sample_t s;
        longint step, key;
        int pick;
        step = (step_raw == 0) ? 1 : longint'(step_raw);
        pick = $urandom_range(99);
        s.start = (pick < 10);
        if (pick < 10 || pick >= 95) begin
            key = ($urandom_range(1) == 0) ? as_long($urandom())
                                           : longint'($urandom_range(32'h0200_0000)) - 64'sh100_0000;
        end else if (pick < 75) begin
            key = walk_key + longint'($urandom_range(600)) * step / 100;
        end else if (pick < 85) begin
            key = walk_key;
        end else if (pick < 90) begin
            key = walk_key - longint'($urandom_range(2)) * step - 1;
        end else begin
            // Long segment that runs past the per-segment point budget.
            key = walk_key + longint'($urandom_range(90, 66)) * step;
        end
        if (key > 64'sd2147483647) key = 64'sd2147483647;
        if (key < -64'sd2147483648) key = -64'sd2147483648;
        walk_key = key;
        s.ch[0] = key[31:0];
        for (int i = 1; i < 7; i++)
            s.ch[i] = $urandom();
        s.typed = 1'b0;
        return s;
    endfunction

    always @(negedge aclk)
        if (aresetn)
            m_tready <= !roll_idle();

    // Checks result beats and watches for a hang.
    always @(posedge aclk) begin
        point_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("uniform_grid_linear_resampler_core: mismatch");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                if (points_due.size() == 0) begin
                    $display("%0t: unexpected beat data=%h last=%b ovf=%b",
                             $realtime, m_tdata, m_tlast, m_tuser);
                    failures++;
                end else begin
                    want = points_due.pop_front();
                    for (int i = 0; i < 7; i++)
                        if (m_tdata[32*i +: 32] !== want.ch[i]) begin
                            $display("%0t: channel %0d expected %h actual %h",
                                     $realtime, i, want.ch[i], m_tdata[32*i +: 32]);
                            failures++;
                        end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last expected %b actual %b", $realtime, want.last, m_tlast);
                        failures++;
                    end
                    if (m_tuser !== want.ovf) begin
                        $display("%0t: overflow expected %b actual %b",
                                 $realtime, want.ovf, m_tuser);
                        failures++;
                    end
                end
            end
        end
    end

    initial begin
        logic [30:0] phase_steps [5];
        phase_steps = '{31'd1, 31'd0, 31'h7FFF_FFFF, 31'd65536, 31'd0};
        phase_steps[4] = 31'(($urandom_range(19, 1)) << 14);

        // Grid step is 1.0 after reset for this part.
        add_row(0, 32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1);
        add_row(0, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h1234_5678, 32'h0000_0001, 0);
        add_row(0, 32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0);
        add_row(0, 32'hFFFF_0000, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h6, 0);
        add_row(0, 32'h0003_8000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h0, 32'hAAAA_AAAA, 32'h5555_5555, 0);
        add_row(1, 32'h7FFF_8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                32'h0001_0000, 32'h0, 1);
        add_row(0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0);
        add_row(1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1);
        add_row(0, 32'h8064_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 0);
        add_row(1, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1);
        add_row(0, 32'h0004_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                32'h1, 32'h0, 32'h0, 0);
        add_row(0, 32'h0004_0001, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 0);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            send_sample(directed_rows[i]);

        for (int phase = 0; phase < 5; phase++) begin
            write_grid_step(phase_steps[phase]);
            calm = (phase == 3);
            walk_key = 0;
            for (int n = 0; n < 24; n++) begin
                if (phase == 1 && n == 12)
                    wait_drained();
                send_sample(random_sample(phase_steps[phase]));
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (failures == 0)
            $display("uniform_grid_linear_resampler_core: match");
        else
            $display("uniform_grid_linear_resampler_core: mismatch");
        $finish;
    end
endmodule
